// File: rtl/kab_pkg.sv
`default_nettype none

package kab_pkg;

   localparam int WORD_W        = 32;
   localparam int COV_FRAC_BITS = 30;
   localparam int OPND_W        = WORD_W + 1;
   localparam int PROD_W        = 2 * OPND_W;
   localparam int SUM_W         = WORD_W + 6;
   localparam int DIV_LANES     = 2;
   localparam int DIV_NUM_W     = WORD_W + COV_FRAC_BITS;

   localparam int MEAS_W  = 25;
   localparam int GYRO_W  = 28;
   localparam int DT_W    = 31;
   localparam int NOISE_W = 30;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DT_W;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_PROCESS_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_PROCESS_NOISE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MEASUREMENT_NOISE   = 2'd3;

   localparam logic [DT_W-1:0]    SAMPLE_PERIOD_RST       = 31'd10737418;
   localparam logic [NOISE_W-1:0] ANGLE_PROCESS_NOISE_RST = 30'd5368709;
   localparam logic [NOISE_W-1:0] BIAS_PROCESS_NOISE_RST  = 30'd3221225;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST   = 30'd32212254;

   typedef enum logic [1:0] {
      MAC_ADD    = 2'd0,
      MAC_MULADD = 2'd1,
      MAC_MULSUB = 2'd2
   } mac_mode_type;

   // ADD:    c + a - b - d
   // MULADD: c + round(a*b >> COV_FRAC_BITS)
   // MULSUB: c - round(a*b >> COV_FRAC_BITS)
   typedef struct packed {
      mac_mode_type             mode;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
      logic signed [OPND_W-1:0] c;
      logic signed [OPND_W-1:0] d;
   } mac_op_type;

   typedef struct packed {
      word_type value;
      logic     clip;
   } mac_res_type;

endpackage

`default_nettype wire

// File: rtl/kab_mac.sv
`default_nettype none

module kab_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  kab_pkg::mac_op_type  op,
   output logic                 res_valid,
   output kab_pkg::mac_res_type res
);
   import kab_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (COV_FRAC_BITS - 1);

   logic                     valid_ff, valid_in;
   mac_mode_type             mode_ff, mode_in;
   logic signed [OPND_W-1:0] c_ff, c_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [PROD_W-1:0] rounded;
   logic signed [SUM_W-1:0]  scaled;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  sum;

   // first stage: product, or a - b - d of the other operands
   always_comb begin
      valid_in = op_valid;
      mode_in  = op.mode;
      c_in     = op.c;
      if (op.mode == MAC_ADD) begin
         prod_in = PROD_W'(op.a) - PROD_W'(op.b) - PROD_W'(op.d);
      end else begin
         prod_in = op.a * op.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      c_ff    <= c_in;
      prod_ff <= prod_in;
   end

   // second stage: round half up, accumulate, saturate
   always_comb begin
      rounded = prod_ff + ROUND_HALF;
      scaled  = SUM_W'(rounded >>> COV_FRAC_BITS);
      case (mode_ff)
         MAC_ADD:    term = SUM_W'(prod_ff);
         MAC_MULADD: term = scaled;
         MAC_MULSUB: term = -scaled;
         default:    term = scaled;
      endcase
      sum = SUM_W'(c_ff) + term;
      if (sum > SUM_W'(WORD_MAX)) begin
         res.value = WORD_MAX;
         res.clip  = 1'b1;
      end else if (sum < SUM_W'(WORD_MIN)) begin
         res.value = WORD_MIN;
         res.clip  = 1'b1;
      end else begin
         res.value = sum[WORD_W-1:0];
         res.clip  = 1'b0;
      end
   end

   assign res_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/kab_div.sv
`default_nettype none

module kab_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  kab_pkg::word_type   numer [kab_pkg::DIV_LANES],
   input  logic [kab_pkg::WORD_W-1:0] denom,
   output logic                done,
   output kab_pkg::word_type   quot [kab_pkg::DIV_LANES],
   output logic                clip
);
   import kab_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(WORD_W - 1);
   localparam logic [WORD_W-1:0] NEG_LIMIT = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_ITER = 3'b010,
      D_FIN  = 3'b100
   } div_state_type;

   div_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] d_ff, d_in;
   logic [WORD_W-1:0] rem_ff [DIV_LANES];
   logic [WORD_W-1:0] rem_in [DIV_LANES];
   logic [WORD_W-1:0] lo_ff  [DIV_LANES];
   logic [WORD_W-1:0] lo_in  [DIV_LANES];
   logic              neg_ff [DIV_LANES];
   logic              neg_in [DIV_LANES];
   logic              ovf_ff [DIV_LANES];
   logic              ovf_in [DIV_LANES];
   word_type          quot_ff [DIV_LANES];
   word_type          quot_in [DIV_LANES];
   logic              clip_ff, clip_in;
   logic              done_ff, done_in;

   logic [WORD_W-1:0]    mag   [DIV_LANES];
   logic [DIV_NUM_W-1:0] num   [DIV_LANES];
   logic [WORD_W:0]      trial [DIV_LANES];
   logic [WORD_W:0]      diff  [DIV_LANES];
   logic                 ge    [DIV_LANES];
   logic                 lane_clip [DIV_LANES];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      quot_in  = quot_ff;
      clip_in  = clip_ff;
      done_in  = 1'b0;

      for (int i = 0; i < DIV_LANES; i++) begin
         mag[i]   = numer[i][WORD_W-1] ? WORD_W'(-numer[i]) : WORD_W'(numer[i]);
         // rounding offset of half the divisor folded into the dividend
         num[i]   = (DIV_NUM_W'(mag[i]) << COV_FRAC_BITS) + DIV_NUM_W'(denom >> 1);
         trial[i] = {rem_ff[i], lo_ff[i][WORD_W-1]};
         diff[i]  = trial[i] - {1'b0, d_ff};
         ge[i]    = trial[i] >= {1'b0, d_ff};
         if (neg_ff[i]) begin
            lane_clip[i] = ovf_ff[i] || (lo_ff[i] > NEG_LIMIT);
         end else begin
            lane_clip[i] = ovf_ff[i] || lo_ff[i][WORD_W-1];
         end
      end

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               d_in   = denom;
               cnt_in = '0;
               for (int i = 0; i < DIV_LANES; i++) begin
                  rem_in[i] = WORD_W'(num[i][DIV_NUM_W-1:WORD_W]);
                  lo_in[i]  = num[i][WORD_W-1:0];
                  neg_in[i] = numer[i][WORD_W-1];
                  // a quotient of 2^WORD_W or more is out of range already
                  ovf_in[i] = WORD_W'(num[i][DIV_NUM_W-1:WORD_W]) >= denom;
               end
               state_in = D_ITER;
            end
         end
         D_ITER: begin
            for (int i = 0; i < DIV_LANES; i++) begin
               rem_in[i] = ge[i] ? diff[i][WORD_W-1:0] : trial[i][WORD_W-1:0];
               lo_in[i]  = {lo_ff[i][WORD_W-2:0], ge[i]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_LAST) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            clip_in = 1'b0;
            for (int i = 0; i < DIV_LANES; i++) begin
               if (lane_clip[i]) begin
                  quot_in[i] = neg_ff[i] ? WORD_MIN : WORD_MAX;
               end else begin
                  quot_in[i] = neg_ff[i] ? -$signed(lo_ff[i]) : $signed(lo_ff[i]);
               end
               clip_in = clip_in | lane_clip[i];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      quot_ff <= quot_in;
      clip_ff <= clip_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign clip = clip_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> state_ff == D_IDLE)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) done |-> $past(state_ff == D_FIN))
      else $error("divider done without finishing");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == D_FIN |-> $past(state_ff == D_ITER) && $past(cnt_ff) == ITER_LAST)
      else $error("divider finished early");

endmodule

`default_nettype wire

// File: rtl/kalman_angle_bias_filter.sv
// Two-state angle and gyro-bias Kalman filter. One transaction on req_ carries an
// accelerometer angle and a gyro rate (Q16.16); one transaction on rsp_ returns the
// fused angle and a flag raised when any value was clipped during that sample. The
// block accepts a sample while req_ready is high, and takes no new one until it has
// loaded the result and returned to idle. Each sample makes fifteen passes through the
// shared multiply-accumulate unit; after the ninth of them come the innovation check and
// the restoring divider that forms both Kalman gains together, one quotient bit per
// cycle, and the sample ends with loading the output register. When the innovation
// variance is not positive the divider is skipped. A finished result waits in the
// output register; the next sample may be accepted and worked on while it waits, and
// it stalls before loading its own result until the waiting one has been taken. Write
// the csr_ registers only while the block is idle.
`default_nettype none

module kalman_angle_bias_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [kab_pkg::MEAS_W-1:0]     req_measured_angle,
   input  logic signed [kab_pkg::GYRO_W-1:0]     req_gyro_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kab_pkg::WORD_W-1:0]     rsp_fused_angle,
   output logic                                  rsp_saturated,
   input  logic                                  csr_wr_en,
   input  logic [kab_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [kab_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import kab_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_ISSUE   = 6'b000010,
      S_WAIT    = 6'b000100,
      S_DIV     = 6'b001000,
      S_DIVWAIT = 6'b010000,
      S_OUT     = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      ST_RATE = 4'd0,
      ST_ANG  = 4'd1,
      ST_T    = 4'd2,
      ST_U    = 4'd3,
      ST_P00  = 4'd4,
      ST_P01  = 4'd5,
      ST_P10  = 4'd6,
      ST_P11  = 4'd7,
      ST_Y    = 4'd8,
      ST_AC   = 4'd9,
      ST_BC   = 4'd10,
      ST_C10  = 4'd11,
      ST_C11  = 4'd12,
      ST_C00  = 4'd13,
      ST_C01  = 4'd14
   } op_step_type;

   state_type    state_ff, state_in;
   op_step_type  step_ff, step_in;
   logic         clip_ff, clip_in;

   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [NOISE_W-1:0] qa_ff, qa_in;
   logic [NOISE_W-1:0] qb_ff, qb_in;
   logic [NOISE_W-1:0] r_ff, r_in;

   word_type angle_ff, angle_in;
   word_type bias_ff, bias_in;
   word_type p_ff [4];
   word_type p_in [4];

   word_type                 t_ff, t_in;
   word_type                 tmp_ff, tmp_in;
   word_type                 gain_ff [DIV_LANES];
   word_type                 gain_in [DIV_LANES];
   logic signed [MEAS_W-1:0] meas_ff, meas_in;
   logic signed [GYRO_W-1:0] gyro_ff, gyro_in;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_angle_ff, rsp_angle_in;
   logic     rsp_sat_ff, rsp_sat_in;

   logic        mac_op_valid;
   mac_op_type  mac_op;
   logic        mac_res_valid;
   mac_res_type mac_res;

   logic                     div_start;
   word_type                 div_numer [DIV_LANES];
   word_type                 div_quot  [DIV_LANES];
   logic                     div_done;
   logic                     div_clip;
   logic signed [WORD_W+1:0] innov;

   kab_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (mac_op_valid),
      .op        (mac_op),
      .res_valid (mac_res_valid),
      .res       (mac_res)
   );

   assign div_numer[0] = p_ff[0];
   assign div_numer[1] = p_ff[2];
   assign innov = (WORD_W+2)'(p_ff[0]) + $signed((WORD_W+2)'(r_ff));

   kab_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (innov[WORD_W-1:0]),
      .done  (div_done),
      .quot  (div_quot),
      .clip  (div_clip)
   );

   // operand selection for the shared unit
   always_comb begin
      mac_op.mode = MAC_ADD;
      mac_op.a    = '0;
      mac_op.b    = '0;
      mac_op.c    = '0;
      mac_op.d    = '0;
      case (step_ff)
         ST_RATE: begin
            mac_op.c = OPND_W'(gyro_ff);
            mac_op.b = OPND_W'(bias_ff);
         end
         ST_ANG: begin
            mac_op.mode = MAC_MULADD;
            mac_op.c    = OPND_W'(angle_ff);
            mac_op.a    = OPND_W'(dt_ff);
            mac_op.b    = OPND_W'(tmp_ff);
         end
         ST_T: begin
            mac_op.mode = MAC_MULADD;
            mac_op.a    = OPND_W'(dt_ff);
            mac_op.b    = OPND_W'(p_ff[3]);
         end
         ST_U: begin
            mac_op.c = OPND_W'(t_ff);
            mac_op.a = OPND_W'(qa_ff);
            mac_op.b = OPND_W'(p_ff[1]);
            mac_op.d = OPND_W'(p_ff[2]);
         end
         ST_P00: begin
            mac_op.mode = MAC_MULADD;
            mac_op.c    = OPND_W'(p_ff[0]);
            mac_op.a    = OPND_W'(dt_ff);
            mac_op.b    = OPND_W'(tmp_ff);
         end
         ST_P01: begin
            mac_op.c = OPND_W'(p_ff[1]);
            mac_op.b = OPND_W'(t_ff);
         end
         ST_P10: begin
            mac_op.c = OPND_W'(p_ff[2]);
            mac_op.b = OPND_W'(t_ff);
         end
         ST_P11: begin
            mac_op.mode = MAC_MULADD;
            mac_op.c    = OPND_W'(p_ff[3]);
            mac_op.a    = OPND_W'(qb_ff);
            mac_op.b    = OPND_W'(dt_ff);
         end
         ST_Y: begin
            mac_op.c = OPND_W'(meas_ff);
            mac_op.b = OPND_W'(angle_ff);
         end
         ST_AC: begin
            mac_op.mode = MAC_MULADD;
            mac_op.c    = OPND_W'(angle_ff);
            mac_op.a    = OPND_W'(gain_ff[0]);
            mac_op.b    = OPND_W'(tmp_ff);
         end
         ST_BC: begin
            mac_op.mode = MAC_MULADD;
            mac_op.c    = OPND_W'(bias_ff);
            mac_op.a    = OPND_W'(gain_ff[1]);
            mac_op.b    = OPND_W'(tmp_ff);
         end
         // P10 and P11 first, so that they see P00 and P01 before correction
         ST_C10: begin
            mac_op.mode = MAC_MULSUB;
            mac_op.c    = OPND_W'(p_ff[2]);
            mac_op.a    = OPND_W'(gain_ff[1]);
            mac_op.b    = OPND_W'(p_ff[0]);
         end
         ST_C11: begin
            mac_op.mode = MAC_MULSUB;
            mac_op.c    = OPND_W'(p_ff[3]);
            mac_op.a    = OPND_W'(gain_ff[1]);
            mac_op.b    = OPND_W'(p_ff[1]);
         end
         ST_C00: begin
            mac_op.mode = MAC_MULSUB;
            mac_op.c    = OPND_W'(p_ff[0]);
            mac_op.a    = OPND_W'(gain_ff[0]);
            mac_op.b    = OPND_W'(p_ff[0]);
         end
         ST_C01: begin
            mac_op.mode = MAC_MULSUB;
            mac_op.c    = OPND_W'(p_ff[1]);
            mac_op.a    = OPND_W'(gain_ff[0]);
            mac_op.b    = OPND_W'(p_ff[1]);
         end
         default: mac_op.mode = MAC_ADD;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clip_in      = clip_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      tmp_in       = tmp_ff;
      gain_in      = gain_ff;
      meas_in      = meas_ff;
      gyro_in      = gyro_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_sat_in   = rsp_sat_ff;
      mac_op_valid = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               meas_in  = req_measured_angle;
               gyro_in  = req_gyro_rate;
               clip_in  = 1'b0;
               step_in  = ST_RATE;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            mac_op_valid = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (mac_res_valid) begin
               clip_in = clip_ff | mac_res.clip;
               case (step_ff) inside
                  ST_RATE, ST_U, ST_Y: tmp_in   = mac_res.value;
                  ST_ANG, ST_AC:       angle_in = mac_res.value;
                  ST_T:                t_in     = mac_res.value;
                  ST_P00, ST_C00:      p_in[0]  = mac_res.value;
                  ST_P01, ST_C01:      p_in[1]  = mac_res.value;
                  ST_P10, ST_C10:      p_in[2]  = mac_res.value;
                  ST_P11, ST_C11:      p_in[3]  = mac_res.value;
                  ST_BC:               bias_in  = mac_res.value;
                  default:             tmp_in   = tmp_ff;
               endcase
               if (step_ff == ST_Y) begin
                  state_in = S_DIV;
               end else if (step_ff == ST_C01) begin
                  state_in = S_OUT;
               end else begin
                  step_in  = op_step_type'(step_ff + 4'd1);
                  state_in = S_ISSUE;
               end
            end
         end
         S_DIV: begin
            // no gain when the innovation variance is not positive
            if (innov > 0) begin
               div_start = 1'b1;
               state_in  = S_DIVWAIT;
            end else begin
               gain_in[0] = '0;
               gain_in[1] = '0;
               step_in    = ST_AC;
               state_in   = S_ISSUE;
            end
         end
         S_DIVWAIT: begin
            if (div_done) begin
               gain_in  = div_quot;
               clip_in  = clip_ff | div_clip;
               step_in  = ST_AC;
               state_in = S_ISSUE;
            end
         end
         S_OUT: begin
            // hold until the previous result has been taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_sat_in   = clip_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_comb begin
      dt_in = dt_ff;
      qa_in = qa_ff;
      qb_in = qb_ff;
      r_in  = r_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_SAMPLE_PERIOD:       dt_in = csr_wdata[DT_W-1:0];
            REG_ANGLE_PROCESS_NOISE: qa_in = csr_wdata[NOISE_W-1:0];
            REG_BIAS_PROCESS_NOISE:  qb_in = csr_wdata[NOISE_W-1:0];
            REG_MEASUREMENT_NOISE:   r_in  = csr_wdata[NOISE_W-1:0];
            default:                 dt_in = dt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_RATE;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= SAMPLE_PERIOD_RST;
         qa_ff        <= ANGLE_PROCESS_NOISE_RST;
         qb_ff        <= BIAS_PROCESS_NOISE_RST;
         r_ff         <= MEASUREMENT_NOISE_RST;
         angle_ff     <= '0;
         bias_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            p_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         dt_ff        <= dt_in;
         qa_ff        <= qa_in;
         qb_ff        <= qb_in;
         r_ff         <= r_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p_ff         <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      tmp_ff       <= tmp_in;
      gain_ff      <= gain_in;
      meas_ff      <= meas_in;
      gyro_ff      <= gyro_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fused_angle = rsp_angle_ff;
   assign rsp_saturated   = rsp_sat_ff;

   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready |=> state_ff == S_ISSUE && step_ff == ST_RATE)
      else $error("accepted transaction did not start the sequence");
   assert property (@(posedge clock) disable iff (reset)
                    mac_res_valid |-> $past(state_ff == S_ISSUE))
      else $error("unit result without an issued operation");
   assert property (@(posedge clock) disable iff (reset)
                    div_done |-> state_ff == S_DIVWAIT)
      else $error("gains arrived while not waiting for them");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == S_OUT && rsp_valid_ff && !rsp_ready |=> state_ff == S_OUT)
      else $error("result overwrote one not yet taken");

endmodule

`default_nettype wire
